/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file spt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/spt_pkg.sv */
package spt_pkg;

   localparam int SEGMENTS_DEF = 4;
   localparam int PAGES_PER_SEGMENT_DEF = 8;
   localparam int FRAMES_DEF = 64;

   localparam int SEG_REGS = 4;
   localparam int SEG_SEL_W = 2;
   localparam int BASE_W = 20;
   localparam int LIMIT_W = 4;
   localparam int ADDR_W = 21;
   localparam int SEGN_W = 3;
   localparam int PAGE_W = 4;
   localparam int OFF_W = 13;
   localparam int PB_W = 13;
   localparam int NSEG_W = 3;
   localparam int FIU_W = 7;
   localparam int CSR_DATA_W = 25;
   localparam int CSR_IDX_W = 3;
   localparam int STATUS_W = 3;
   localparam int IDX_WIDE_W = 8;

   localparam logic [PB_W-1:0] PAGE_BYTES_RST = 13'd1024;
   localparam logic [FIU_W-1:0] FRAMES_IN_USE_RST = 7'd64;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_SEGMENT = 3'd1,
      ST_PAGE_LIMIT  = 3'd2,
      ST_OFFSET      = 3'd3,
      ST_WRITE_PROT  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEGMENT0        = 3'd0,
      CSR_SEGMENT1        = 3'd1,
      CSR_SEGMENT2        = 3'd2,
      CSR_SEGMENT3        = 3'd3,
      CSR_SEGMENTS_IN_USE = 3'd4,
      CSR_PAGE_BYTES      = 3'd5,
      CSR_FRAMES_IN_USE   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_MULT,
      FSM_EMIT
   } fsm_type;

   // Segment descriptor, bit 24 writable, 23:20 page limit, 19:0 base.
   typedef struct packed {
      logic                writable;
      logic [LIMIT_W-1:0]  limit;
      logic [BASE_W-1:0]   base;
   } segment_type;

endpackage

/* rtl/core/spt_table.sv */
module spt_table #(
   parameter int DEPTH = 32,
   parameter int AW = 5,
   parameter int FW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_present,
   output logic          rd_writable,
   output logic [FW-1:0] rd_frame,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_writable,
   input  logic [FW-1:0] wr_frame
);

   logic [FW:0]    mem_ff [DEPTH];
   logic [FW:0]    rd_data_ff;
   logic [DEPTH-1:0] present_ff;
   logic           rd_present_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_writable, wr_frame};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Present bits reset to clear; the frame memory is trusted only behind them.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         rd_present_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            present_ff[wr_addr] <= 1'b1;
         end
         rd_present_ff <= present_ff[rd_addr];
      end
   end

   assign rd_present  = rd_present_ff;
   assign rd_writable = rd_data_ff[FW];
   assign rd_frame    = rd_data_ff[FW-1:0];

endmodule

/* rtl/core/spt_alloc.sv */
module spt_alloc #(
   parameter int FRAMES = spt_pkg::FRAMES_DEF,
   parameter int FW = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [spt_pkg::FIU_W-1:0] frames_in_use,
   input  logic                      take,
   output logic [FW-1:0]             frame
);

   localparam int CW = $clog2(FRAMES + 1);

   logic [CW-1:0] handed_ff;
   logic [CW-1:0] handed_in;
   logic [FW-1:0] ptr_ff;
   logic [FW-1:0] ptr_in;
   logic [CW-1:0] lim;
   logic [FW-1:0] reuse;

   always_comb begin
      if (frames_in_use == '0) begin
         lim = CW'(1);
      end else if (frames_in_use > FRAMES) begin
         lim = CW'(FRAMES);
      end else begin
         lim = CW'(frames_in_use);
      end
   end

   always_comb begin
      reuse     = (CW'(ptr_ff) < lim) ? ptr_ff : '0;
      handed_in = handed_ff;
      ptr_in    = ptr_ff;
      if (handed_ff < lim) begin
         frame     = handed_ff[FW-1:0];
         handed_in = handed_ff + CW'(1);
      end else begin
         frame  = reuse;
         ptr_in = ((CW'(reuse) + CW'(1)) >= lim) ? '0 : reuse + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handed_ff <= '0;
         ptr_ff    <= '0;
      end else if (take) begin
         handed_ff <= handed_in;
         ptr_ff    <= ptr_in;
      end
   end

endmodule

/* rtl/core/segmented_paging_translator.sv */
// Segmented, paged address translator. The page table memory is read on the
// accepting edge; then the lookup step checks the access and allocates a frame
// on a miss (writing the table back), the multiply step forms the frame times
// page size product and the emit step forms the address and registers it. A
// new access is accepted only once the FSM is back in idle after the emit
// step; a result left waiting in the output register stalls only the final
// step. Faults return a zero address. The page table valid bits clear at
// reset, so no clearing pass is needed.
module segmented_paging_translator #(
   parameter int SEGMENTS = spt_pkg::SEGMENTS_DEF,
   parameter int PAGES_PER_SEGMENT = spt_pkg::PAGES_PER_SEGMENT_DEF,
   parameter int FRAMES = spt_pkg::FRAMES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // segment_number [2:0], page_number [6:3], page_offset [19:7]
   input  logic [23:0]                    req_tdata,
   // is_write [0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // physical_address [20:0]
   output logic [23:0]                    rsp_tdata,
   // status [2:0], frame_allocated [3]
   output logic [3:0]                     rsp_tuser,
   input  logic                           csr_we,
   input  logic [spt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = SEGMENTS * PAGES_PER_SEGMENT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(FRAMES);
   localparam int PROD_W = FW + spt_pkg::PB_W;
   localparam int LIMW = spt_pkg::LIMIT_W + 1;

   // configuration
   spt_pkg::segment_type             seg_cfg_ff [spt_pkg::SEG_REGS];
   logic [spt_pkg::NSEG_W-1:0]       nseg_cfg_ff;
   logic [spt_pkg::PB_W-1:0]         page_bytes_ff;
   logic [spt_pkg::FIU_W-1:0]        frames_in_use_ff;

   // request fields
   logic [spt_pkg::SEGN_W-1:0]       in_seg;
   logic [spt_pkg::PAGE_W-1:0]       in_page;
   logic [spt_pkg::OFF_W-1:0]        in_off;
   logic [spt_pkg::IDX_WIDE_W-1:0]   idx_wide;
   logic [AW-1:0]                    idx;

   logic [spt_pkg::SEGN_W-1:0]       seg_ff;
   logic [spt_pkg::PAGE_W-1:0]       page_ff;
   logic [spt_pkg::OFF_W-1:0]        off_ff;
   logic                             wr_ff;
   logic [AW-1:0]                    idx_ff;

   spt_pkg::fsm_type                 state_ff;
   spt_pkg::fsm_type                 state_in;
   logic                             accept;
   logic                             emit;

   // lookup stage
   logic                             tbl_present;
   logic                             tbl_writable;
   logic [FW-1:0]                    tbl_frame;
   logic [FW-1:0]                    alloc_frame;
   logic [spt_pkg::NSEG_W-1:0]       nseg;
   spt_pkg::segment_type             seg_sel;
   logic [LIMW-1:0]                  page_lim;
   spt_pkg::status_type              status;
   logic                             hit;
   logic                             need_alloc;

   logic [FW-1:0]                    frame_ff;
   spt_pkg::status_type              status_ff;
   logic                             alloc_ff;
   logic [spt_pkg::BASE_W-1:0]       base_ff;
   logic [PROD_W-1:0]                prod_ff;
   logic [spt_pkg::ADDR_W-1:0]       addr;

   logic                             rsp_tvalid_ff;
   logic [spt_pkg::ADDR_W-1:0]       rsp_addr_ff;
   spt_pkg::status_type              rsp_status_ff;
   logic                             rsp_alloc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spt_pkg::SEG_REGS; i++) begin
            seg_cfg_ff[i] <= '0;
         end
         nseg_cfg_ff      <= '0;
         page_bytes_ff    <= spt_pkg::PAGE_BYTES_RST;
         frames_in_use_ff <= spt_pkg::FRAMES_IN_USE_RST;
      end else if (csr_we) begin
         unique case (spt_pkg::csr_index_type'(csr_index))
            spt_pkg::CSR_SEGMENT0: seg_cfg_ff[0] <= csr_wdata;
            spt_pkg::CSR_SEGMENT1: seg_cfg_ff[1] <= csr_wdata;
            spt_pkg::CSR_SEGMENT2: seg_cfg_ff[2] <= csr_wdata;
            spt_pkg::CSR_SEGMENT3: seg_cfg_ff[3] <= csr_wdata;
            spt_pkg::CSR_SEGMENTS_IN_USE: begin
               nseg_cfg_ff <= csr_wdata[spt_pkg::NSEG_W-1:0];
            end
            spt_pkg::CSR_PAGE_BYTES: begin
               page_bytes_ff <= csr_wdata[spt_pkg::PB_W-1:0];
            end
            spt_pkg::CSR_FRAMES_IN_USE: begin
               frames_in_use_ff <= csr_wdata[spt_pkg::FIU_W-1:0];
            end
            default: ;
         endcase
      end
   end

   assign in_seg  = req_tdata[2:0];
   assign in_page = req_tdata[6:3];
   assign in_off  = req_tdata[19:7];

   // Table index straight from the beat, so the read lands in the lookup cycle.
   always_comb begin
      idx_wide = spt_pkg::IDX_WIDE_W'(in_seg) * spt_pkg::IDX_WIDE_W'(PAGES_PER_SEGMENT)
               + spt_pkg::IDX_WIDE_W'(in_page);
      idx = (idx_wide >= DEPTH) ? '0 : idx_wide[AW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         spt_pkg::FSM_IDLE: begin
            accept = req_tvalid;
            if (req_tvalid) begin
               state_in = spt_pkg::FSM_LOOKUP;
            end
         end
         spt_pkg::FSM_LOOKUP: state_in = spt_pkg::FSM_MULT;
         spt_pkg::FSM_MULT:   state_in = spt_pkg::FSM_EMIT;
         spt_pkg::FSM_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               emit     = 1'b1;
               state_in = spt_pkg::FSM_IDLE;
            end
         end
         default: state_in = spt_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spt_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == spt_pkg::FSM_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_ff  <= in_seg;
         page_ff <= in_page;
         off_ff  <= in_off;
         wr_ff   <= req_tuser;
         idx_ff  <= idx;
      end
   end

   always_comb begin
      nseg = nseg_cfg_ff;
      if (nseg > SEGMENTS) begin
         nseg = spt_pkg::NSEG_W'(SEGMENTS);
      end
      if (nseg > spt_pkg::SEG_REGS) begin
         nseg = spt_pkg::NSEG_W'(spt_pkg::SEG_REGS);
      end
      seg_sel  = seg_cfg_ff[seg_ff[spt_pkg::SEG_SEL_W-1:0]];
      page_lim = (seg_sel.limit > PAGES_PER_SEGMENT) ? LIMW'(PAGES_PER_SEGMENT)
                                                     : LIMW'(seg_sel.limit);
      if (seg_ff >= nseg) begin
         status = spt_pkg::ST_BAD_SEGMENT;
      end else if (LIMW'(page_ff) >= page_lim) begin
         status = spt_pkg::ST_PAGE_LIMIT;
      end else if (off_ff >= page_bytes_ff) begin
         status = spt_pkg::ST_OFFSET;
      end else if (wr_ff && !seg_sel.writable) begin
         status = spt_pkg::ST_WRITE_PROT;
      end else begin
         status = spt_pkg::ST_OK;
      end
      // A write to a page installed read-only counts as a miss.
      hit        = tbl_present && !(wr_ff && !tbl_writable);
      need_alloc = (state_ff == spt_pkg::FSM_LOOKUP) && (status == spt_pkg::ST_OK) && !hit;
   end

   spt_table #(
      .DEPTH(DEPTH),
      .AW(AW),
      .FW(FW)
   ) u_spt_table (
      .clock(clock),
      .reset(reset),
      .rd_addr(idx),
      .rd_present(tbl_present),
      .rd_writable(tbl_writable),
      .rd_frame(tbl_frame),
      .wr_en(need_alloc),
      .wr_addr(idx_ff),
      .wr_writable(wr_ff),
      .wr_frame(alloc_frame)
   );

   spt_alloc #(
      .FRAMES(FRAMES),
      .FW(FW)
   ) u_spt_alloc (
      .clock(clock),
      .reset(reset),
      .frames_in_use(frames_in_use_ff),
      .take(need_alloc),
      .frame(alloc_frame)
   );

   always_ff @(posedge clock) begin
      if (state_ff == spt_pkg::FSM_LOOKUP) begin
         frame_ff  <= hit ? tbl_frame : alloc_frame;
         status_ff <= status;
         alloc_ff  <= need_alloc;
         base_ff   <= seg_sel.base;
      end
      if (state_ff == spt_pkg::FSM_MULT) begin
         prod_ff <= PROD_W'(frame_ff) * PROD_W'(page_bytes_ff);
      end
   end

   // Wraps modulo the address width.
   assign addr = (status_ff == spt_pkg::ST_OK)
               ? spt_pkg::ADDR_W'(base_ff) + spt_pkg::ADDR_W'(prod_ff)
                 + spt_pkg::ADDR_W'(off_ff)
               : '0;

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_addr_ff   <= addr;
         rsp_status_ff <= status_ff;
         rsp_alloc_ff  <= alloc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_addr_ff};
   assign rsp_tuser  = {rsp_alloc_ff, rsp_status_ff};

endmodule

/* rtl/core/spt_checker.sv */
`include "assert_macros.svh"

module spt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   `SPT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")
   `SPT_ASSERT_SAME(a_fault_zero, clock, reset, rsp_tvalid && (rsp_tuser[2:0] != spt_pkg::ST_OK), (rsp_tdata == 24'd0) && !rsp_tuser[3], "fault beat carries address or allocation")
   `SPT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second access taken while one is in flight")

endmodule

bind segmented_paging_translator spt_checker u_spt_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
